// ----- sv/bkrd_pkg.sv -----
// Shared types and constants for the boot keyboard report diff block.
package bkrd_pkg;

   localparam int KEY_SLOTS      = 6;
   localparam int INPUT_SLOTS    = 6;
   localparam int MIN_REPORT_LEN = 8;
   localparam int MAX_EVENTS     = 13;
   localparam int EVT_BITS       = 2 * KEY_SLOTS + 1;
   localparam int EVT_IDX_W      = $clog2(EVT_BITS);
   localparam int SLOT_IDX_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int CNT_W          = $clog2(MAX_EVENTS + 1);
   localparam int LIMIT_W        = 4;
   localparam int LIMIT_RESET    = 13;
   localparam int FIFO_DEPTH     = 2;
   localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);
   localparam int CSR_ADDR_W     = 3;

   localparam logic [CSR_ADDR_W-3:0] CSR_REG_EVENT_LIMIT = '0;

   typedef enum logic [1:0] {
      EVT_PRESS    = 2'd0,
      EVT_RELEASE  = 2'd1,
      EVT_MODIFIER = 2'd2
   } evt_kind_type;

   typedef logic [KEY_SLOTS-1:0][7:0] key_row_type;

   // One classified report waiting for the event walker.
   typedef struct packed {
      key_row_type         cur_keys;
      key_row_type         prev_keys;
      logic [7:0]          mods;
      logic [EVT_BITS-1:0] mask;  // press slots, then release slots, then modifier
      logic [CNT_W-1:0]    cap;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

// ----- sv/bkrd_if.sv -----
// Report and event channel interfaces.
interface bkrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] report_length;
   logic [7:0] modifier_bits;
   logic [7:0] slot0_key;
   logic [7:0] slot1_key;
   logic [7:0] slot2_key;
   logic [7:0] slot3_key;
   logic [7:0] slot4_key;
   logic [7:0] slot5_key;

   modport source (output valid, report_length, modifier_bits, slot0_key, slot1_key,
                   slot2_key, slot3_key, slot4_key, slot5_key, input ready);
   modport sink   (input valid, report_length, modifier_bits, slot0_key, slot1_key,
                   slot2_key, slot3_key, slot4_key, slot5_key, output ready);
endinterface

interface bkrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [7:0] key_code;
   logic [7:0] out_modifiers;
   logic       last_event;

   modport source (output valid, event_kind, key_code, out_modifiers, last_event,
                   input ready);
   modport sink   (input valid, event_kind, key_code, out_modifiers, last_event,
                   output ready);
endinterface

// ----- sv/bkrd_front.sv -----
// Front end: takes reports, diffs them against the stored slots, builds descriptors.
module bkrd_front
   import bkrd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   bkrd_req_if.sink            req_bus,
   input  logic [LIMIT_W-1:0]  event_limit,
   input  fifo_stat_type       fifo_stat,
   output logic                push,
   output desc_type            push_desc
);

   key_row_type         prev_ff;
   key_row_type         prev_in;
   logic [7:0]          slot_in [INPUT_SLOTS];
   key_row_type         cur;
   logic [KEY_SLOTS-1:0] press;
   logic [KEY_SLOTS-1:0] release_m;
   logic [EVT_BITS-1:0] mask;
   logic [CNT_W-1:0]    cap;
   logic                accept;
   logic                long_enough;

   always_comb begin
      slot_in[0] = req_bus.slot0_key;
      slot_in[1] = req_bus.slot1_key;
      slot_in[2] = req_bus.slot2_key;
      slot_in[3] = req_bus.slot3_key;
      slot_in[4] = req_bus.slot4_key;
      slot_in[5] = req_bus.slot5_key;
   end

   // Slots beyond the six carried in a report read as empty.
   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (i < INPUT_SLOTS) begin
            cur[i] = slot_in[i % INPUT_SLOTS];
         end else begin
            cur[i] = 8'd0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         press[i]     = (cur[i] != 8'd0);
         release_m[i] = (prev_ff[i] != 8'd0);
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (prev_ff[j] == cur[i]) press[i] = 1'b0;
            if (cur[j] == prev_ff[i]) release_m[i] = 1'b0;
         end
      end
      mask = {(req_bus.modifier_bits != 8'd0), release_m, press};
   end

   always_comb begin
      if (event_limit > LIMIT_W'(MAX_EVENTS)) begin
         cap = CNT_W'(MAX_EVENTS);
      end else begin
         cap = CNT_W'(event_limit);
      end
   end

   assign req_bus.ready = !fifo_stat.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign long_enough   = (req_bus.report_length >= 8'(MIN_REPORT_LEN));

   // A report that yields no event still moves the stored slots.
   assign push = accept && long_enough && (cap != '0) && (mask != '0);

   always_comb begin
      push_desc.cur_keys  = cur;
      push_desc.prev_keys = prev_ff;
      push_desc.mods      = req_bus.modifier_bits;
      push_desc.mask      = mask;
      push_desc.cap       = cap;
   end

   always_comb begin
      prev_in = prev_ff;
      if (accept && long_enough) prev_in = cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

// ----- sv/bkrd_fifo.sv -----
// Short descriptor queue between the front end and the event walker.
module bkrd_fifo
   import bkrd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  desc_type      push_desc,
   input  logic          pop,
   output desc_type      pop_desc,
   output fifo_stat_type stat
);

   desc_type              entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_in;
   logic [FIFO_CNT_W-1:0] cnt_ff;
   logic [FIFO_CNT_W-1:0] cnt_in;
   logic                  do_push;
   logic                  do_pop;

   assign stat.full  = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_desc   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_desc;
   end

endmodule

// ----- sv/bkrd_back.sv -----
// Event walker: emits one event beat per cycle from the current descriptor while rsp_bus is not stalled.
module bkrd_back
   import bkrd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  fifo_stat_type fifo_stat,
   input  desc_type      pop_desc,
   output logic          pop,
   bkrd_rsp_if.source    rsp_bus
);

   logic                work_valid_ff;
   logic                work_valid_in;
   desc_type            desc_ff;
   desc_type            desc_in;
   logic [EVT_BITS-1:0] mask_ff;
   logic [EVT_BITS-1:0] mask_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;

   logic                out_valid_ff;
   logic                out_valid_in;
   evt_kind_type        out_kind_ff;
   evt_kind_type        out_kind_in;
   logic [7:0]          out_code_ff;
   logic [7:0]          out_code_in;
   logic [7:0]          out_mods_ff;
   logic [7:0]          out_mods_in;
   logic                out_last_ff;
   logic                out_last_in;

   logic                emit;
   logic                last;
   logic [EVT_IDX_W-1:0] idx;
   logic [EVT_BITS-1:0] mask_next;

   // Lowest pending event first: presses, then releases, then the modifier.
   always_comb begin
      idx = '0;
      for (int i = EVT_BITS - 1; i >= 0; i--) begin
         if (mask_ff[i]) idx = EVT_IDX_W'(i);
      end
   end

   always_comb begin
      mask_next      = mask_ff;
      mask_next[idx] = 1'b0;
   end

   assign emit = work_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign last = (mask_next == '0) || ((count_ff + 1'b1) == desc_ff.cap);
   assign pop  = !fifo_stat.empty && (!work_valid_ff || (emit && last));

   always_comb begin
      work_valid_in = work_valid_ff;
      desc_in       = desc_ff;
      mask_in       = mask_ff;
      count_in      = count_ff;
      if (emit) begin
         mask_in  = mask_next;
         count_in = count_ff + 1'b1;
         if (last) work_valid_in = 1'b0;
      end
      if (pop) begin
         work_valid_in = 1'b1;
         desc_in       = pop_desc;
         mask_in       = pop_desc.mask;
         count_in      = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_code_in  = out_code_ff;
      out_mods_in  = out_mods_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_last_in  = last;
         if (int'(idx) < KEY_SLOTS) begin
            out_kind_in = EVT_PRESS;
            out_code_in = desc_ff.cur_keys[SLOT_IDX_W'(idx)];
            out_mods_in = 8'd0;
         end else if (int'(idx) < 2 * KEY_SLOTS) begin
            out_kind_in = EVT_RELEASE;
            out_code_in = desc_ff.prev_keys[SLOT_IDX_W'(idx - EVT_IDX_W'(KEY_SLOTS))];
            out_mods_in = 8'd0;
         end else begin
            out_kind_in = EVT_MODIFIER;
            out_code_in = 8'd0;
            out_mods_in = desc_ff.mods;
         end
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      mask_ff     <= mask_in;
      count_ff    <= count_in;
      out_kind_ff <= out_kind_in;
      out_code_ff <= out_code_in;
      out_mods_ff <= out_mods_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.event_kind    = out_kind_ff;
   assign rsp_bus.key_code      = out_code_ff;
   assign rsp_bus.out_modifiers = out_mods_ff;
   assign rsp_bus.last_event    = out_last_ff;

   a_work_pending: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff |-> (mask_ff != '0) && (count_ff < desc_ff.cap))
      else $error("walker holds a descriptor with nothing left to emit");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_stat.empty)
      else $error("walker popped an empty queue");

   a_last_ends_work: assert property (@(posedge clock) disable iff (reset)
      (emit && last && !pop) |=> !work_valid_ff)
      else $error("walker kept going past the last event beat");

endmodule

// ----- sv/boot_keyboard_report_diff.sv -----
// Top level: boot keyboard report diff with APB-style limit register.
//
//   channel   dir   handshake            carries
//   req_bus   in    valid/ready          one keyboard report per beat
//   rsp_bus   out   valid/ready          one press/release/modifier event per beat
//   csr_*     in    APB write/read       event_limit at byte address 0
//
// The front end takes one report per cycle while the two-entry descriptor queue has room.
// The walker emits one event per cycle while rsp_bus is not stalled, and holds each report
// until its events (1 to 13) are out; reports giving no event never enter the queue.
// The first event passes through the queue entry, the walker descriptor and the output register.
// Reset clears the stored key slots, the queue and the output; event_limit returns to 13.
// A stalled result side backs up through the queue into req_bus.ready.
module boot_keyboard_report_diff
   import bkrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bkrd_req_if.sink              req_bus,
   bkrd_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;
   logic               csr_hit;
   logic               push;
   logic               pop;
   desc_type           push_desc;
   desc_type           pop_desc;
   fifo_stat_type      fifo_stat;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_REG_EVENT_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_hit) csr_prdata = {{(32 - LIMIT_W){1'b0}}, limit_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_W'(LIMIT_RESET);
      end else begin
         limit_ff <= limit_in;
      end
   end

   bkrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .event_limit (limit_ff),
      .fifo_stat   (fifo_stat),
      .push        (push),
      .push_desc   (push_desc)
   );

   bkrd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .stat      (fifo_stat)
   );

   bkrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .fifo_stat (fifo_stat),
      .pop_desc  (pop_desc),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ----- tb/bkrd_event_checker.sv -----
`timescale 1ns / 100ps
// Event checker: predicts the press/release/modifier events for each report and compares.
module bkrd_event_checker
   import bkrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bkrd_req_if                   req_mon,
   bkrd_rsp_if                   rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic [31:0]           csr_prdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      evt_kind_type kind;
      logic [7:0]   key;
      logic [7:0]   mods;
      logic         last;
   } key_event_type;

   key_event_type       expected_events[$];
   key_row_type         held_keys;
   logic [LIMIT_W-1:0]  limit_shadow;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= 40)
         $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
   endtask

   function automatic bit row_has(input key_row_type row, input logic [7:0] k);
      for (int i = 0; i < KEY_SLOTS; i++)
         if (row[i] == k) return 1'b1;
      return 1'b0;
   endfunction

   task automatic predict_events(input logic [7:0] len, input logic [7:0] mods,
                                 input key_row_type cur);
      key_event_type evs[$];
      int            cap;
      if (len < MIN_REPORT_LEN) return;
      // 14 and 15 saturate at the hard cap
      cap = (limit_shadow > MAX_EVENTS) ? MAX_EVENTS : int'(limit_shadow);
      for (int i = 0; i < KEY_SLOTS; i++)
         if (cur[i] != 8'h00 && !row_has(held_keys, cur[i]) && evs.size() < cap)
            evs.push_back('{EVT_PRESS, cur[i], 8'h00, 1'b0});
      for (int i = 0; i < KEY_SLOTS; i++)
         if (held_keys[i] != 8'h00 && !row_has(cur, held_keys[i]) && evs.size() < cap)
            evs.push_back('{EVT_RELEASE, held_keys[i], 8'h00, 1'b0});
      if (mods != 8'h00 && evs.size() < cap)
         evs.push_back('{EVT_MODIFIER, 8'h00, mods, 1'b0});
      if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
      foreach (evs[j]) expected_events.push_back(evs[j]);
      held_keys = cur;
   endtask

   task automatic check_event();
      key_event_type want;
      if (expected_events.size() == 0) begin
         report_mismatch("event beat with nothing expected, key", rsp_mon.key_code, 0);
         return;
      end
      want = expected_events.pop_front();
      if (rsp_mon.event_kind !== want.kind)
         report_mismatch("event_kind", rsp_mon.event_kind, want.kind);
      if (rsp_mon.key_code !== want.key)
         report_mismatch("key_code", rsp_mon.key_code, want.key);
      if (rsp_mon.out_modifiers !== want.mods)
         report_mismatch("out_modifiers", rsp_mon.out_modifiers, want.mods);
      if (rsp_mon.last_event !== want.last)
         report_mismatch("last_event", rsp_mon.last_event, want.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_keys    = '0;
         limit_shadow = LIMIT_W'(LIMIT_RESET);
         expected_events.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_event();
         if (req_mon.valid && req_mon.ready)
            predict_events(req_mon.report_length, req_mon.modifier_bits,
                           {req_mon.slot5_key, req_mon.slot4_key, req_mon.slot3_key,
                            req_mon.slot2_key, req_mon.slot1_key, req_mon.slot0_key});
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_REG_EVENT_LIMIT) begin
            if (csr_pwrite)
               limit_shadow = csr_pwdata[LIMIT_W-1:0];
            else if (csr_prdata[LIMIT_W-1:0] !== limit_shadow)
               report_mismatch("event_limit readback", csr_prdata, limit_shadow);
         end
      end
      pending <= expected_events.size();
   end

endmodule

// ----- tb/boot_keyboard_report_diff_tb.sv -----
`timescale 1ns / 100ps
// Testbench top: report stimulus, event-side stalls, limit register phases and verdict.
module boot_keyboard_report_diff_tb;
   import bkrd_pkg::*;

   localparam int DRAIN_CYCLES  = 6;
   localparam int PHASES        = 8;
   localparam int PHASE_REPORTS = 25;

   typedef struct packed {
      logic [7:0]  len;
      logic [7:0]  mods;
      key_row_type keys;
   } kb_report_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending;
   int                    burst_left;
   int                    stall_left;
   key_row_type           last_keys;
   logic [LIMIT_W-1:0]    phase_limits [PHASES] = '{4'd0, 4'd15, 4'd1, 4'd14, 4'd13,
                                                   4'd5, 4'd2, 4'd9};

   bkrd_req_if req_bus ();
   bkrd_rsp_if rsp_bus ();

   boot_keyboard_report_diff uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   bkrd_event_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

   // Event-side stalls: short stalls, long open stretches, and choppy toggling.
   initial begin
      int mode;
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left == 0) begin
            mode = $urandom_range(0, 9);
            if (mode < 3) begin
               rsp_bus.ready <= 1'b0;
               stall_left = $urandom_range(1, 8);
            end else if (mode < 5) begin
               rsp_bus.ready <= 1'b1;
               stall_left = $urandom_range(20, 60);
            end else begin
               rsp_bus.ready <= 1'($urandom_range(0, 1));
               stall_left = $urandom_range(0, 3);
            end
         end else begin
            stall_left--;
         end
      end
   end

   task automatic send_report(input kb_report_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_bus.valid         <= 1'b1;
      req_bus.report_length <= r.len;
      req_bus.modifier_bits <= r.mods;
      req_bus.slot0_key     <= r.keys[0];
      req_bus.slot1_key     <= r.keys[1];
      req_bus.slot2_key     <= r.keys[2];
      req_bus.slot3_key     <= r.keys[3];
      req_bus.slot4_key     <= r.keys[4];
      req_bus.slot5_key     <= r.keys[5];
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
      // reports that give no event may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [LIMIT_W-1:0] val);
      logic [31:0] word;
      word = $urandom();
      word[LIMIT_W-1:0] = val;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {CSR_REG_EVENT_LIMIT, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed reports that reuse keys from the last report, plus noise.
   function automatic kb_report_type random_report();
      kb_report_type r;
      int            pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         r.len  = 8'($urandom());
         r.mods = 8'($urandom());
         for (int i = 0; i < KEY_SLOTS; i++) r.keys[i] = 8'($urandom());
      end else begin
         r.len  = (pick < 25) ? 8'($urandom_range(0, MIN_REPORT_LEN - 1)) :
                  ($urandom_range(0, 1) ? 8'(MIN_REPORT_LEN) :
                                          8'($urandom_range(MIN_REPORT_LEN, 255)));
         r.mods = ($urandom_range(0, 9) < 4) ? 8'h00 : 8'($urandom());
         for (int i = 0; i < KEY_SLOTS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      r.keys[i] = last_keys[$urandom_range(0, KEY_SLOTS - 1)];
            else if (pick < 60) r.keys[i] = 8'h00;
            else if (pick < 85) r.keys[i] = 8'($urandom_range(4, 10));
            else                r.keys[i] = 8'($urandom());
         end
      end
      if (r.len >= MIN_REPORT_LEN) last_keys = r.keys;
      return r;
   endfunction

   initial begin
      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.report_length <= '0;
      req_bus.modifier_bits <= '0;
      req_bus.slot0_key     <= '0;
      req_bus.slot1_key     <= '0;
      req_bus.slot2_key     <= '0;
      req_bus.slot3_key     <= '0;
      req_bus.slot4_key     <= '0;
      req_bus.slot5_key     <= '0;
      burst_left = 0;
      last_keys  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the limit
      csr_access(1'b0, '0);

      // directed: empty report, full press, short reports, full thirteen-event diff,
      // repeated keys, unchanged keys in another order, all released
      send_report('{8'd8,   8'h00, 48'h000000000000});
      send_report('{8'd8,   8'hFF, 48'h090807060504});
      send_report('{8'd7,   8'h5A, 48'h123456789ABC});
      send_report('{8'd0,   8'hFF, 48'hFFFFFFFFFFFF});
      send_report('{8'd255, 8'h80, 48'hFFFFFFFFFFFF});
      send_report('{8'd8,   8'h00, 48'h060504030201});
      send_report('{8'd8,   8'h01, 48'h060504030201});
      send_report('{8'd8,   8'h00, 48'h010203040506});
      send_report('{8'd9,   8'h00, 48'h080700000404});
      send_report('{8'd8,   8'h7F, 48'h000000000000});
      send_report('{8'd128, 8'hAA, 48'h010810204080});
      send_report('{8'd8,   8'h55, 48'hFE7FFD01FB02});
      send_report('{8'd1,   8'h00, 48'h000000000000});
      send_report('{8'd8,   8'h00, 48'hFE7FFD01FB02});
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         csr_access(1'b1, (p >= 6) ? LIMIT_W'($urandom_range(0, 15)) : phase_limits[p]);
         csr_access(1'b0, '0);
         repeat (PHASE_REPORTS) send_report(random_report());
         wait_drained();
      end

      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
